>>> design/ir_pulse_distance_decoder_defines.svh
// Assertion macros for the IR pulse-distance decoder.
// Used by the top level; needs a clock named clock and a reset named reset.
`ifndef IR_PULSE_DISTANCE_DECODER_DEFINES_SVH
`define IR_PULSE_DISTANCE_DECODER_DEFINES_SVH

// same-cycle implication
`define IRPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IRPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/irpd_pkg.sv
// Shared types, constants and helpers for the IR pulse-distance decoder.
// No dependencies.
`default_nettype none

package irpd_pkg;

   localparam int unsigned DUR_W    = 16;
   localparam int unsigned LEN_W    = 7;
   localparam int unsigned DATA_W   = 64;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [DUR_W-1:0] PREAMBLE_TOLERANCE_US = 16'd500;

   localparam logic [DUR_W-1:0] RST_PREAMBLE_MARK  = 16'd9000;
   localparam logic [DUR_W-1:0] RST_PREAMBLE_SPACE = 16'd4500;
   localparam logic [DUR_W-1:0] RST_ONE_MARK       = 16'd560;
   localparam logic [DUR_W-1:0] RST_ONE_SPACE      = 16'd1690;
   localparam logic [DUR_W-1:0] RST_ZERO_MARK      = 16'd560;
   localparam logic [DUR_W-1:0] RST_ZERO_SPACE     = 16'd560;
   localparam logic [LEN_W-1:0] RST_FRAME_BITS     = 7'd32;
   localparam logic [DUR_W-1:0] RST_BIT_TOL        = 16'd200;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PREAMBLE_MARK  = 3'd0,
      REG_PREAMBLE_SPACE = 3'd1,
      REG_ONE_MARK       = 3'd2,
      REG_ONE_SPACE      = 3'd3,
      REG_ZERO_MARK      = 3'd4,
      REG_ZERO_SPACE     = 3'd5,
      REG_FRAME_BITS     = 3'd6,
      REG_BIT_TOL        = 3'd7
   } irpd_reg_type;

   typedef enum logic {
      MODE_SEEK = 1'b0,
      MODE_DATA = 1'b1
   } irpd_mode_type;

   typedef struct packed {
      logic [DUR_W-1:0] preamble_mark_us;
      logic [DUR_W-1:0] preamble_space_us;
      logic [DUR_W-1:0] one_mark_us;
      logic [DUR_W-1:0] one_space_us;
      logic [DUR_W-1:0] zero_mark_us;
      logic [DUR_W-1:0] zero_space_us;
      logic [LEN_W-1:0] frame_bit_count;
      logic [DUR_W-1:0] bit_tolerance_us;
   } irpd_cfg_type;

   // strict window: nominal - tol < x < nominal + tol
   function automatic logic in_window(input logic [DUR_W-1:0] x,
                                      input logic [DUR_W-1:0] nominal,
                                      input logic [DUR_W-1:0] tol);
      logic signed [DUR_W+1:0] xs;
      logic signed [DUR_W+1:0] lo;
      logic signed [DUR_W+1:0] hi;
      xs = signed'({2'b00, x});
      lo = signed'({2'b00, nominal}) - signed'({2'b00, tol});
      hi = signed'({2'b00, nominal}) + signed'({2'b00, tol});
      return (xs > lo) && (xs < hi);
   endfunction

endpackage

`default_nettype wire

>>> design/irpd_csr.sv
// Configuration registers of the IR pulse-distance decoder.
// Depends on irpd_pkg.
`default_nettype none

module irpd_csr
   import irpd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DUR_W-1:0]     csr_wdata,
   output irpd_cfg_type              cfg
);

   irpd_cfg_type cfg_ff;
   irpd_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (irpd_reg_type'(csr_index))
            REG_PREAMBLE_MARK:  cfg_in.preamble_mark_us  = csr_wdata;
            REG_PREAMBLE_SPACE: cfg_in.preamble_space_us = csr_wdata;
            REG_ONE_MARK:       cfg_in.one_mark_us       = csr_wdata;
            REG_ONE_SPACE:      cfg_in.one_space_us      = csr_wdata;
            REG_ZERO_MARK:      cfg_in.zero_mark_us      = csr_wdata;
            REG_ZERO_SPACE:     cfg_in.zero_space_us     = csr_wdata;
            REG_FRAME_BITS:     cfg_in.frame_bit_count   = csr_wdata[LEN_W-1:0];
            REG_BIT_TOL:        cfg_in.bit_tolerance_us  = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_mark_us  <= RST_PREAMBLE_MARK;
         cfg_ff.preamble_space_us <= RST_PREAMBLE_SPACE;
         cfg_ff.one_mark_us       <= RST_ONE_MARK;
         cfg_ff.one_space_us      <= RST_ONE_SPACE;
         cfg_ff.zero_mark_us      <= RST_ZERO_MARK;
         cfg_ff.zero_space_us     <= RST_ZERO_SPACE;
         cfg_ff.frame_bit_count   <= RST_FRAME_BITS;
         cfg_ff.bit_tolerance_us  <= RST_BIT_TOL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> design/irpd_core.sv
// Decoder state and single-pass next-state logic: preamble search,
// bit decode and stop-mark check. Depends on irpd_pkg.
`default_nettype none

module irpd_core
   import irpd_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BITS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire irpd_cfg_type      cfg,
   input  wire logic              step,
   input  wire logic              line_level,
   input  wire logic [DUR_W-1:0]  interval_us,
   output logic                   emit,
   output logic [DATA_W-1:0]      frame_data,
   output logic [LEN_W-1:0]       frame_length
);

   localparam int unsigned CNT_W = $clog2(MAX_FRAME_BITS + 1);
   localparam int unsigned IDX_W = $clog2(MAX_FRAME_BITS);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BITS);

   irpd_mode_type             mode_ff, mode_in;
   logic                      held_ff, held_in;     // one interval pending
   logic [DUR_W-1:0]          held_us_ff;
   logic                      prev_level_ff;
   logic [CNT_W-1:0]          bits_ff, bits_in;
   logic [MAX_FRAME_BITS-1:0] store_ff, store_in;

   logic [LEN_W-1:0]          len;
   logic                      pair;
   logic                      bits_full;
   logic                      stop_ok, one_ok, zero_ok, pre_hit;
   logic                      do_seek;
   logic [MAX_FRAME_BITS-1:0] len_mask;

   always_comb begin
      if (cfg.frame_bit_count == '0) begin
         len = LEN_W'(1);
      end else if (cfg.frame_bit_count > MAX_LEN) begin
         len = MAX_LEN;
      end else begin
         len = cfg.frame_bit_count;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_FRAME_BITS; i++) begin
         len_mask[i] = (LEN_W'(i) < len);
      end
   end

   // a repeated level discards the pending interval
   assign pair      = held_ff && (prev_level_ff != line_level);
   assign bits_full = (LEN_W'(bits_ff) >= len);

   assign stop_ok = in_window(interval_us, cfg.one_mark_us, cfg.bit_tolerance_us);
   assign one_ok  = in_window(held_us_ff, cfg.one_mark_us, cfg.bit_tolerance_us)
                 && in_window(interval_us, cfg.one_space_us, cfg.bit_tolerance_us);
   assign zero_ok = in_window(held_us_ff, cfg.zero_mark_us, cfg.bit_tolerance_us)
                 && in_window(interval_us, cfg.zero_space_us, cfg.bit_tolerance_us);
   assign pre_hit = in_window(held_us_ff, cfg.preamble_mark_us, PREAMBLE_TOLERANCE_US)
                 && in_window(interval_us, cfg.preamble_space_us, PREAMBLE_TOLERANCE_US);

   always_comb begin
      mode_in  = mode_ff;
      held_in  = 1'b0;
      bits_in  = bits_ff;
      store_in = store_ff;
      emit     = 1'b0;
      do_seek  = 1'b0;

      case (mode_ff)
         MODE_DATA: begin
            if (!pair) begin
               if (bits_full) begin
                  if (stop_ok) begin
                     emit    = 1'b1;
                     mode_in = MODE_SEEK;
                  end else begin
                     do_seek = 1'b1;
                  end
               end else begin
                  held_in = 1'b1;
               end
            end else if (!bits_full && (one_ok || zero_ok)) begin
               if (one_ok) begin
                  store_in[bits_ff[IDX_W-1:0]] = 1'b1;
               end
               bits_in = bits_ff + CNT_W'(1);
            end else begin
               do_seek = 1'b1;
            end
         end
         default: do_seek = 1'b1;
      endcase

      // preamble search; the new interval must end a space to close a pair
      if (do_seek) begin
         mode_in = MODE_SEEK;
         if (!pair) begin
            held_in = !line_level;
         end else if (!line_level) begin
            held_in = 1'b1;
         end else if (pre_hit) begin
            mode_in  = MODE_DATA;
            bits_in  = '0;
            store_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_SEEK;
         held_ff       <= 1'b0;
         prev_level_ff <= 1'b0;
         bits_ff       <= '0;
      end else if (step) begin
         mode_ff       <= mode_in;
         held_ff       <= held_in;
         prev_level_ff <= line_level;
         bits_ff       <= bits_in;
      end
   end

   // any pending interval left after a step is always the newest one
   always_ff @(posedge clock) begin
      if (step) begin
         held_us_ff <= interval_us;
         store_ff   <= store_in;
      end
   end

   assign frame_data   = DATA_W'(store_ff & len_mask);
   assign frame_length = len;

endmodule

`default_nettype wire

>>> design/ir_pulse_distance_decoder.sv
// Top level of the IR pulse-distance decoder: input register, decoder core,
// result register and configuration port. Depends on irpd_pkg, irpd_csr,
// irpd_core and ir_pulse_distance_decoder_defines.svh.
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_line_level, req_interval_us
//   rsp      out        rsp_valid, rsp_ready, rsp_frame_data, rsp_frame_length
//   csr      in         csr_write_enable, csr_index, csr_wdata
//
// One item per cycle while no waiting result holds the decode stage; a result is
// valid once the item that closes the frame has passed the input register and
// the decode logic and its output has been captured in the result register.
// Synchronous active-high reset; configuration returns to its defaults.
// A waiting result holds the decode stage; one further item is buffered.
`default_nettype none
`include "ir_pulse_distance_decoder_defines.svh"

module ir_pulse_distance_decoder
   import irpd_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BITS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_line_level,
   input  wire logic [DUR_W-1:0]     req_interval_us,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [DATA_W-1:0]         rsp_frame_data,
   output logic [LEN_W-1:0]          rsp_frame_length,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DUR_W-1:0]     csr_wdata
);

   irpd_cfg_type     cfg;

   logic             in_valid_ff;
   logic             in_level_ff;
   logic [DUR_W-1:0] in_interval_ff;

   logic             advance;
   logic             emit;
   logic [DATA_W-1:0] core_data;
   logic [LEN_W-1:0] core_length;

   logic             rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [LEN_W-1:0] rsp_length_ff;

   irpd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_level_ff    <= req_line_level;
         in_interval_ff <= req_interval_us;
      end
   end

   irpd_core #(
      .MAX_FRAME_BITS (MAX_FRAME_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .step         (advance),
      .line_level   (in_level_ff),
      .interval_us  (in_interval_ff),
      .emit         (emit),
      .frame_data   (core_data),
      .frame_length (core_length)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_data_ff   <= core_data;
         rsp_length_ff <= core_length;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_data   = rsp_data_ff;
   assign rsp_frame_length = rsp_length_ff;

   `IRPD_ASSERT_NEXT(a_emit_reaches_rsp, advance && emit, rsp_valid && rsp_frame_length == $past(core_length), "decoded frame not captured")
   `IRPD_ASSERT_NOW(a_len_range, rsp_valid, rsp_frame_length != '0 && rsp_frame_length <= LEN_W'(MAX_FRAME_BITS), "frame length out of range")
   `IRPD_ASSERT_NOW(a_upper_zero, rsp_valid, (rsp_frame_data >> rsp_frame_length) == '0, "bits above frame length set")

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// Testbench for ir_pulse_distance_decoder: sends interval items, predicts the decoded frames
// with a local model of the decoder and checks every frame result in arrival order.
// Depends on irpd_pkg and the decoder RTL.

module tb
   import irpd_pkg::*;
();

   localparam int unsigned FRAME_BITS_MAX = 64;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned REPORT_LIMIT   = 10;
   localparam logic        MARK           = 1'b0;
   localparam logic        SPACE          = 1'b1;

   typedef enum {FLAW_NONE, FLAW_BIT, FLAW_STOP, FLAW_REPEAT} flaw_type;
   typedef enum {BITS_MORE, BITS_DONE, BITS_BAD} bits_status_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [LEN_W-1:0]  length;
   } frame_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_line_level = 1'b0;
   logic [DUR_W-1:0]     req_interval_us = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [DATA_W-1:0]    rsp_frame_data;
   logic [LEN_W-1:0]     rsp_frame_length;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DUR_W-1:0]     csr_wdata = '0;

   // decoder model state
   irpd_cfg_type      cfg;
   logic [DUR_W-1:0]  held_us [3];
   int unsigned       held_n;
   logic              last_level;
   irpd_mode_type     mode;
   int unsigned       bit_n;
   logic [DATA_W-1:0] bit_acc;
   frame_type         frames_due [$];

   int unsigned items_sent  = 0;
   int unsigned fault_count = 0;
   int unsigned cycle_count = 0;
   int unsigned idle_odds   = 0;
   int unsigned stall_left  = 0;

   ir_pulse_distance_decoder #(
      .MAX_FRAME_BITS(FRAME_BITS_MAX)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_line_level  (req_line_level),
      .req_interval_us (req_interval_us),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_data  (rsp_frame_data),
      .rsp_frame_length(rsp_frame_length),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic bit hits(logic [DUR_W-1:0] x, logic [DUR_W-1:0] nominal,
                               logic [DUR_W-1:0] tol);
      int lo;
      int hi;
      lo = int'(nominal) - int'(tol);
      hi = int'(nominal) + int'(tol);
      return (int'(x) > lo) && (int'(x) < hi);
   endfunction

   function automatic int unsigned frame_len();
      if (cfg.frame_bit_count == 0)
         return 1;
      if (cfg.frame_bit_count > FRAME_BITS_MAX)
         return FRAME_BITS_MAX;
      return cfg.frame_bit_count;
   endfunction

   function automatic void drop_pair();
      held_us[0] = held_us[2];
      held_us[1] = '0;
      held_us[2] = '0;
      held_n -= 2;
   endfunction

   function automatic bits_status_type take_bits(int unsigned flen);
      while (1'b1) begin
         if (bit_n >= flen && held_n == 1) begin
            if (hits(held_us[0], cfg.one_mark_us, cfg.bit_tolerance_us)) begin
               held_n = 0;
               return BITS_DONE;
            end
            return BITS_BAD;
         end
         if (held_n < 2)
            return BITS_MORE;
         if (bit_n >= flen)
            return BITS_BAD;
         if (hits(held_us[0], cfg.one_mark_us, cfg.bit_tolerance_us)
               && hits(held_us[1], cfg.one_space_us, cfg.bit_tolerance_us)) begin
            bit_acc[bit_n % DATA_W] = 1'b1;
         end else if (!(hits(held_us[0], cfg.zero_mark_us, cfg.bit_tolerance_us)
               && hits(held_us[1], cfg.zero_space_us, cfg.bit_tolerance_us))) begin
            return BITS_BAD;
         end
         bit_n = (bit_n + 1) % 128;
         drop_pair();
      end
      return BITS_MORE;
   endfunction

   function automatic bit seek_preamble(logic level);
      bit hit;
      // align so the oldest held interval is a mark
      if (((level + held_n + 1) % 2) == 1 && held_n > 0) begin
         held_us[0] = held_us[1];
         held_us[1] = held_us[2];
         held_us[2] = '0;
         held_n--;
      end
      while (held_n >= 2) begin
         hit = hits(held_us[0], cfg.preamble_mark_us, PREAMBLE_TOLERANCE_US)
            && hits(held_us[1], cfg.preamble_space_us, PREAMBLE_TOLERANCE_US);
         drop_pair();
         if (hit)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void decode_interval(logic level, logic [DUR_W-1:0] dur);
      int unsigned     flen;
      bits_status_type st;
      frame_type       fr;
      flen = frame_len();
      if (last_level == level)
         held_n = 0;
      last_level = level;
      if (held_n < 3) begin
         held_us[held_n] = dur;
         held_n++;
      end
      if (mode == MODE_DATA) begin
         st = take_bits(flen);
         if (st == BITS_MORE)
            return;
         mode = MODE_SEEK;
         if (st == BITS_DONE) begin
            fr.data   = (flen >= DATA_W) ? bit_acc : bit_acc & ((64'd1 << flen) - 64'd1);
            fr.length = LEN_W'(flen);
            frames_due.push_back(fr);
            return;
         end
      end
      if (seek_preamble(level)) begin
         mode    = MODE_DATA;
         bit_n   = 0;
         bit_acc = '0;
      end
   endfunction

   function automatic void reset_model();
      cfg.preamble_mark_us  = RST_PREAMBLE_MARK;
      cfg.preamble_space_us = RST_PREAMBLE_SPACE;
      cfg.one_mark_us       = RST_ONE_MARK;
      cfg.one_space_us      = RST_ONE_SPACE;
      cfg.zero_mark_us      = RST_ZERO_MARK;
      cfg.zero_space_us     = RST_ZERO_SPACE;
      cfg.frame_bit_count   = RST_FRAME_BITS;
      cfg.bit_tolerance_us  = RST_BIT_TOL;
      held_us    = '{default: '0};
      held_n     = 0;
      last_level = 1'b0;
      mode       = MODE_SEEK;
      bit_n      = 0;
      bit_acc    = '0;
   endfunction

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : check_frames
      frame_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frames_due.size() == 0) begin
            if (fault_count < REPORT_LIMIT)
               $display("unexpected frame: data %h length %0d",
                        rsp_frame_data, rsp_frame_length);
            fault_count++;
         end else begin
            want = frames_due.pop_front();
            if (rsp_frame_data !== want.data || rsp_frame_length !== want.length) begin
               if (fault_count < REPORT_LIMIT)
                  $display("frame mismatch: data exp %h got %h, length exp %0d got %0d",
                           want.data, rsp_frame_data, want.length, rsp_frame_length);
               fault_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         stall_left = $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_interval(logic level, logic [DUR_W-1:0] dur);
      req_valid       <= 1'b1;
      req_line_level  <= level;
      req_interval_us <= dur;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      decode_interval(level, dur);
      items_sent++;
      @(negedge clock);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
   endtask

   task automatic write_reg(irpd_reg_type idx, logic [DUR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      case (idx)
         REG_PREAMBLE_MARK:  cfg.preamble_mark_us  = value;
         REG_PREAMBLE_SPACE: cfg.preamble_space_us = value;
         REG_ONE_MARK:       cfg.one_mark_us       = value;
         REG_ONE_SPACE:      cfg.one_space_us      = value;
         REG_ZERO_MARK:      cfg.zero_mark_us      = value;
         REG_ZERO_SPACE:     cfg.zero_space_us     = value;
         REG_FRAME_BITS:     cfg.frame_bit_count   = value[LEN_W-1:0];
         REG_BIT_TOL:        cfg.bit_tolerance_us  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // upper write-data bits are don't-care for the frame length register
   task automatic set_frame_bits(logic [LEN_W-1:0] n);
      logic [DUR_W-1:0] value;
      value            = DUR_W'($urandom);
      value[LEN_W-1:0] = n;
      write_reg(REG_FRAME_BITS, value);
   endtask

   task automatic set_timing(logic [DUR_W-1:0] pm, logic [DUR_W-1:0] ps,
                             logic [DUR_W-1:0] om, logic [DUR_W-1:0] os,
                             logic [DUR_W-1:0] zm, logic [DUR_W-1:0] zs,
                             logic [DUR_W-1:0] tol);
      write_reg(REG_PREAMBLE_MARK, pm);
      write_reg(REG_PREAMBLE_SPACE, ps);
      write_reg(REG_ONE_MARK, om);
      write_reg(REG_ONE_SPACE, os);
      write_reg(REG_ZERO_MARK, zm);
      write_reg(REG_ZERO_SPACE, zs);
      write_reg(REG_BIT_TOL, tol);
   endtask

   // drain all expected frames, then give the pipeline time to empty
   task automatic settle();
      req_valid <= 1'b0;
      while (frames_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [DUR_W-1:0] jittered(logic [DUR_W-1:0] nominal,
                                                 logic [DUR_W-1:0] tol);
      int v;
      if (tol <= 1)
         return nominal;
      v = int'(nominal) + int'($urandom_range(0, 2 * (tol - 1))) - int'(tol - 1);
      if (v < 0)
         v = 0;
      if (v > 65535)
         v = 65535;
      return DUR_W'(v);
   endfunction

   task automatic send_preamble();
      send_interval(MARK, jittered(cfg.preamble_mark_us, PREAMBLE_TOLERANCE_US));
      send_interval(SPACE, jittered(cfg.preamble_space_us, PREAMBLE_TOLERANCE_US));
   endtask

   task automatic send_bit(logic b);
      if (b) begin
         send_interval(MARK, jittered(cfg.one_mark_us, cfg.bit_tolerance_us));
         send_interval(SPACE, jittered(cfg.one_space_us, cfg.bit_tolerance_us));
      end else begin
         send_interval(MARK, jittered(cfg.zero_mark_us, cfg.bit_tolerance_us));
         send_interval(SPACE, jittered(cfg.zero_space_us, cfg.bit_tolerance_us));
      end
   endtask

   task automatic send_stop();
      send_interval(MARK, jittered(cfg.one_mark_us, cfg.bit_tolerance_us));
   endtask

   task automatic send_frame(logic [DATA_W-1:0] bits, flaw_type flaw);
      int unsigned flen;
      int unsigned at;
      flen = frame_len();
      at   = $urandom_range(0, flen - 1);
      if ($urandom_range(0, 1) == 1)
         send_interval(SPACE, DUR_W'($urandom_range(5000, 65535)));
      send_preamble();
      for (int unsigned i = 0; i < flen; i++) begin
         if (flaw == FLAW_BIT && i == at) begin
            send_interval(MARK, DUR_W'($urandom));
            send_interval(SPACE, DUR_W'($urandom));
         end else begin
            send_bit(bits[i]);
         end
         if (flaw == FLAW_REPEAT && i == at)
            send_interval(SPACE, jittered(cfg.one_space_us, cfg.bit_tolerance_us));
      end
      if (flaw == FLAW_STOP)
         send_interval(MARK, DUR_W'($urandom));
      else
         send_stop();
   endtask

   task automatic send_noise(int unsigned n);
      repeat (n) begin
         if ($urandom_range(0, 1) == 1)
            send_interval(1'($urandom), DUR_W'($urandom));
         else
            send_interval(1'($urandom), jittered(cfg.one_space_us, 1000));
      end
   endtask

   task automatic random_traffic(int unsigned budget);
      int unsigned stop_at;
      int unsigned pick;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 19);
         if (pick < 13)
            send_frame({$urandom, $urandom}, FLAW_NONE);
         else if (pick < 15)
            send_frame({$urandom, $urandom}, FLAW_BIT);
         else if (pick < 16)
            send_frame({$urandom, $urandom}, FLAW_STOP);
         else if (pick < 17)
            send_frame({$urandom, $urandom}, FLAW_REPEAT);
         else
            send_noise($urandom_range(1, 8));
      end
   endtask

   function automatic logic [DUR_W-1:0] pick_us();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return DUR_W'($urandom_range(100, 12000));
      endcase
   endfunction

   function automatic logic [DUR_W-1:0] pick_tol();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return DUR_W'($urandom_range(1, 400));
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_level_repeat_extremes();
      send_interval(MARK, '0);
      send_interval(MARK, '1);
      send_interval(SPACE, '1);
      send_interval(SPACE, '0);
      settle();
   endtask

   task automatic test_short_frame();
      set_frame_bits(7'd2);
      send_frame(64'b01, FLAW_NONE);
      settle();
   endtask

   // a second preamble fails as a bit and is rescanned as a new preamble
   task automatic test_rescan_after_bad_bit();
      send_preamble();
      send_preamble();
      send_bit(1'b1);
      send_bit(1'b0);
      send_stop();
      settle();
   endtask

   task automatic test_zero_tolerance();
      write_reg(REG_BIT_TOL, '0);
      set_frame_bits(7'd1);
      send_frame(64'b1, FLAW_NONE);
      settle();
      write_reg(REG_BIT_TOL, RST_BIT_TOL);
   endtask

   task automatic test_length_clamp();
      set_frame_bits(7'd0);
      send_frame(64'b1, FLAW_NONE);
      settle();
   endtask

   task automatic test_length_change_midframe();
      set_frame_bits(7'd4);
      send_preamble();
      send_bit(1'b1);
      send_bit(1'b0);
      settle();
      set_frame_bits(7'd1);
      send_stop();
      settle();
      // two intervals held once the length is reached
      set_frame_bits(7'd4);
      send_preamble();
      send_bit(1'b0);
      send_bit(1'b1);
      send_interval(MARK, jittered(cfg.one_mark_us, cfg.bit_tolerance_us));
      settle();
      set_frame_bits(7'd2);
      send_interval(SPACE, jittered(cfg.one_space_us, cfg.bit_tolerance_us));
      settle();
   endtask

   task automatic test_default_timing();
      set_timing(RST_PREAMBLE_MARK, RST_PREAMBLE_SPACE, RST_ONE_MARK, RST_ONE_SPACE,
                 RST_ZERO_MARK, RST_ZERO_SPACE, RST_BIT_TOL);
      set_frame_bits(RST_FRAME_BITS);
      random_traffic(250);
      settle();
   endtask

   task automatic test_distinct_bit_timing();
      set_timing(16'd4500, 16'd4500, 16'd600, 16'd1600, 16'd1200, 16'd400, 16'd150);
      set_frame_bits(7'd8);
      random_traffic(350);
      settle();
   endtask

   task automatic test_long_frames();
      set_timing(RST_PREAMBLE_MARK, RST_PREAMBLE_SPACE, RST_ONE_MARK, RST_ONE_SPACE,
                 RST_ZERO_MARK, RST_ZERO_SPACE, RST_BIT_TOL);
      set_frame_bits(7'd127);
      random_traffic(200);
      settle();
      set_frame_bits(7'd64);
      random_traffic(100);
      settle();
   endtask

   task automatic test_random_timing();
      repeat (4) begin
         set_timing(pick_us(), pick_us(), pick_us(), pick_us(), pick_us(), pick_us(),
                    pick_tol());
         set_frame_bits(LEN_W'($urandom_range(0, 12)));
         random_traffic(100);
         settle();
      end
   endtask

   task automatic test_full_rate();
      idle_odds = 0;
      set_timing(RST_PREAMBLE_MARK, RST_PREAMBLE_SPACE, RST_ONE_MARK, RST_ONE_SPACE,
                 RST_ZERO_MARK, RST_ZERO_SPACE, RST_BIT_TOL);
      set_frame_bits(7'd4);
      random_traffic(250);
      settle();
   endtask

   initial begin
      reset_model();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_odds = 4;
      test_level_repeat_extremes();
      test_short_frame();
      test_rescan_after_bad_bit();
      test_zero_tolerance();
      test_length_clamp();
      test_length_change_midframe();
      idle_odds = 6;
      test_default_timing();
      idle_odds = 3;
      test_distinct_bit_timing();
      idle_odds = 10;
      test_long_frames();
      idle_odds = 5;
      test_random_timing();
      test_full_rate();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fault_count == 0 && frames_due.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
